>>> hw/rtl/tbs_pkg.sv
package tbs_pkg;

  localparam int CountMax = 65535;
  localparam logic [15:0] CntMax = 16'(CountMax);
  localparam logic [15:0] PosMax = 16'hFFFF;
  localparam logic [30:0] SumMax = 31'h7FFF_FFFF;
  localparam logic [14:0] LowestReset = 15'h7FFF;

  localparam logic [14:0] NormalLimitReset = 15'd464;
  localparam logic [14:0] WarningLimitReset = 15'd704;
  localparam logic [14:0] CriticalLimitReset = 15'd944;
  localparam logic [14:0] TripLevelReset = 15'd720;

  typedef enum logic [1:0] {
    CfgNormalLimit = 2'd0,
    CfgWarningLimit = 2'd1,
    CfgCriticalLimit = 2'd2,
    CfgTripLevel = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ActSample = 1'b0,
    ActClear = 1'b1
  } action_e;

  typedef struct packed {
    logic              action;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic [14:0] min_seen;
    logic [14:0] max_seen;
    logic [30:0] total;
    logic [15:0] skipped_count;
    logic [15:0] normal_count;
    logic [15:0] warning_count;
    logic [15:0] critical_count;
    logic [15:0] shutdown_count;
    logic        trip_seen;
    logic [15:0] trip_index;
  } out_t;

  typedef struct packed {
    logic [14:0] normal_limit;
    logic [14:0] warning_limit;
    logic [14:0] critical_limit;
    logic [14:0] trip_level;
  } cfg_t;

  localparam out_t StatsReset = '{
    min_seen: LowestReset,
    max_seen: 15'd0,
    total: 31'd0,
    skipped_count: 16'd0,
    normal_count: 16'd0,
    warning_count: 16'd0,
    critical_count: 16'd0,
    shutdown_count: 16'd0,
    trip_seen: 1'b0,
    trip_index: 16'd0
  };

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v >= CntMax) ? CntMax : v + 16'd1;
  endfunction

endpackage

>>> hw/rtl/tbs_cfg_regs.sv
module tbs_cfg_regs import tbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgNormalLimit:   cfg_d.normal_limit = cfg_data_i;
        CfgWarningLimit:  cfg_d.warning_limit = cfg_data_i;
        CfgCriticalLimit: cfg_d.critical_limit = cfg_data_i;
        CfgTripLevel:     cfg_d.trip_level = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        normal_limit: NormalLimitReset,
        warning_limit: WarningLimitReset,
        critical_limit: CriticalLimitReset,
        trip_level: TripLevelReset
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/tbs_stats.sv
module tbs_stats import tbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  input  cfg_t cfg_i,
  input  logic res_free_i,
  output logic res_push_o,
  output out_t res_data_o
);

  logic        in_valid_q;
  in_t         in_q;
  logic        advance;
  out_t        stats_d, stats_q;
  logic [15:0] pos_d, pos_q;
  logic [14:0] t;
  logic [31:0] sum_wide;
  logic        in_normal, in_warning, in_critical;

  assign advance    = in_valid_q && res_free_i;
  assign in_ready_o = !in_valid_q || advance;

  assign t        = in_q.sample[14:0];
  assign sum_wide = {1'b0, stats_q.total} + {17'd0, t};

  assign in_normal   = t <= cfg_i.normal_limit;
  assign in_warning  = !in_normal && (t <= cfg_i.warning_limit);
  assign in_critical = !in_normal && !in_warning && (t <= cfg_i.critical_limit);

  always_comb begin
    stats_d = stats_q;
    pos_d   = pos_q;
    if (action_e'(in_q.action) == ActClear) begin
      stats_d = StatsReset;
      pos_d   = 16'd0;
    end else if (in_q.sample[15]) begin
      stats_d.skipped_count = sat_inc(stats_q.skipped_count);
      pos_d = (pos_q >= PosMax) ? PosMax : pos_q + 16'd1;
    end else begin
      if (!stats_q.trip_seen && (t >= cfg_i.trip_level)) begin
        stats_d.trip_seen  = 1'b1;
        stats_d.trip_index = pos_q;
      end
      if (t < stats_q.min_seen) stats_d.min_seen = t;
      if (t > stats_q.max_seen) stats_d.max_seen = t;
      stats_d.total = sum_wide[31] ? SumMax : sum_wide[30:0];
      if (in_normal) begin
        stats_d.normal_count = sat_inc(stats_q.normal_count);
      end else if (in_warning) begin
        stats_d.warning_count = sat_inc(stats_q.warning_count);
      end else if (in_critical) begin
        stats_d.critical_count = sat_inc(stats_q.critical_count);
      end else begin
        stats_d.shutdown_count = sat_inc(stats_q.shutdown_count);
      end
      pos_d = (pos_q >= PosMax) ? PosMax : pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      stats_q    <= StatsReset;
      pos_q      <= 16'd0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        stats_q <= stats_d;
        pos_q   <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
  end

  assign res_push_o = advance;
  // trip_index stays zero until the trip latch sets, so it can go out as is
  assign res_data_o = stats_d;

endmodule

>>> hw/rtl/tbs_out_reg.sv
module tbs_out_reg import tbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_push_i,
  input  out_t res_data_i,
  output logic res_free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic out_valid_q;
  out_t out_q;

  assign res_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free_o) begin
      out_valid_q <= res_push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) out_q <= res_data_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/temperature_band_statistics.sv
// Path from input beat to result beat: input register, then result register.
// Throughput: 1 item per cycle unless out_ready_i stalls; the statistics update is a
//   single pass of compares, a 31-bit saturating add and 16-bit saturating increments.
// Reset (rst_ni low, async): statistics cleared, limits back to 464/704/944,
//   trip level 720, both pipeline registers empty.
module temperature_band_statistics import tbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  cfg_t cfg;
  logic res_free;
  logic res_push;
  out_t res_data;

  tbs_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  tbs_stats u_stats (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .cfg_i      (cfg),
    .res_free_i (res_free),
    .res_push_o (res_push),
    .res_data_o (res_data)
  );

  tbs_out_reg u_out (
    .clk_i,
    .rst_ni,
    .res_push_i (res_push),
    .res_data_i (res_data),
    .res_free_o (res_free),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

>>> hw/rtl/tbs_checker.sv
module tbs_checker import tbs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_data_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.trip_seen |-> out_data_o.trip_index == 16'd0)
    else $error("trip index set without trip");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.normal_count != 16'd0) ||
                    (out_data_o.warning_count != 16'd0) ||
                    (out_data_o.critical_count != 16'd0) ||
                    (out_data_o.shutdown_count != 16'd0))
    |-> out_data_o.min_seen <= out_data_o.max_seen)
    else $error("min above max with valid samples");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.max_seen == 15'd0 |-> out_data_o.total == 31'd0)
    else $error("nonzero total with zero max");

endmodule

bind temperature_band_statistics tbs_checker u_tbs_checker (.*);

>>> sim/tb_top.sv
module tb_top;
  import tbs_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int RandPhases = 8;
  localparam int BeatsPerPhase = 130;

  typedef struct {
    action_e     act;
    logic [15:0] smp;
    bit          pinned;
    out_t        want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;

  // predictor state
  cfg_t        limits;
  logic [15:0] pos;
  logic [14:0] lo;
  logic [14:0] hi;
  logic [30:0] acc_sum;
  logic [15:0] skip_cnt;
  logic [15:0] band_cnt [4];
  logic        trip_hit;
  logic [15:0] trip_pos;

  out_t pending_stats [$];
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   cycles = 0;
  int   errors = 0;
  int   checked = 0;
  int   n_samples = 0;
  int   n_clears = 0;
  int   n_settings = 0;

  temperature_band_statistics dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v < CntMax) ? v + 16'd1 : CntMax;
  endfunction

  function automatic void clear_stats();
    pos = '0;
    lo = LowestReset;
    hi = '0;
    acc_sum = '0;
    skip_cnt = '0;
    foreach (band_cnt[i]) band_cnt[i] = '0;
    trip_hit = 1'b0;
    trip_pos = '0;
  endfunction

  function automatic out_t advance_stats(in_t b);
    logic [14:0] t;
    logic [31:0] wide;
    int          band;
    out_t        r;
    if (b.action == ActClear) begin
      clear_stats();
    end else if (b.sample[15]) begin
      skip_cnt = bump16(skip_cnt);
      pos = (pos == PosMax) ? PosMax : pos + 16'd1;
    end else begin
      t = b.sample[14:0];
      if (!trip_hit && t >= limits.trip_level) begin
        trip_hit = 1'b1;
        trip_pos = pos;
      end
      if (t < lo) lo = t;
      if (t > hi) hi = t;
      wide = {1'b0, acc_sum} + 32'(t);
      acc_sum = (wide > 32'(SumMax)) ? SumMax : wide[30:0];
      if (t <= limits.normal_limit) band = 0;
      else if (t <= limits.warning_limit) band = 1;
      else if (t <= limits.critical_limit) band = 2;
      else band = 3;
      band_cnt[band] = bump16(band_cnt[band]);
      pos = (pos == PosMax) ? PosMax : pos + 16'd1;
    end
    r.min_seen = lo;
    r.max_seen = hi;
    r.total = acc_sum;
    r.skipped_count = skip_cnt;
    r.normal_count = band_cnt[0];
    r.warning_count = band_cnt[1];
    r.critical_count = band_cnt[2];
    r.shutdown_count = band_cnt[3];
    r.trip_seen = trip_hit;
    r.trip_index = trip_hit ? trip_pos : 16'd0;
    return r;
  endfunction

  function automatic out_t stats_of(logic [14:0] mn, logic [14:0] mx, logic [30:0] tot,
                                    logic [15:0] sk, logic [15:0] nc, logic [15:0] wc,
                                    logic [15:0] cc, logic [15:0] sc, logic tr,
                                    logic [15:0] ix);
    out_t r;
    r = '{mn, mx, tot, sk, nc, wc, cc, sc, tr, ix};
    return r;
  endfunction

  function automatic in_t rand_item();
    in_t         b;
    int          pick;
    int          v;
    logic [14:0] near;
    b.action = ActSample;
    pick = $urandom_range(99);
    if (pick < 3) begin
      b.action = ActClear;
      b.sample = 16'($urandom);
    end else if (pick < 18) begin
      b.sample = 16'($urandom_range(16'hFFFF, 16'h8000));
    end else if (pick < 40) begin
      b.sample = 16'($urandom);
    end else if (pick < 45) begin
      b.sample = $urandom_range(1) ? 16'h7FFF : 16'h0000;
    end else begin
      case ($urandom_range(3))
        0: near = limits.normal_limit;
        1: near = limits.warning_limit;
        2: near = limits.critical_limit;
        default: near = limits.trip_level;
      endcase
      v = int'(near) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      b.sample = 16'(v);
    end
    return b;
  endfunction

  task automatic send_beat(input in_t b, input bit pinned, input out_t want);
    out_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    r = advance_stats(b);
    pending_stats.push_back(pinned ? want : r);
    if (b.action == ActClear) n_clears++;
    else n_samples++;
  endtask

  task automatic drain();
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(input cfg_t c);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgNormalLimit;
    cfg_data_i <= c.normal_limit;
    @(posedge clk_i);
    cfg_idx_i <= CfgWarningLimit;
    cfg_data_i <= c.warning_limit;
    @(posedge clk_i);
    cfg_idx_i <= CfgCriticalLimit;
    cfg_data_i <= c.critical_limit;
    @(posedge clk_i);
    cfg_idx_i <= CfgTripLevel;
    cfg_data_i <= c.trip_level;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limits = c;
    n_settings++;
  endtask

  task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, got %p", $time, out_data_o);
      end else begin
        e = pending_stats.pop_front();
        checked++;
        check_field("min_seen", 32'(e.min_seen), 32'(out_data_o.min_seen));
        check_field("max_seen", 32'(e.max_seen), 32'(out_data_o.max_seen));
        check_field("total", 32'(e.total), 32'(out_data_o.total));
        check_field("skipped_count", 32'(e.skipped_count), 32'(out_data_o.skipped_count));
        check_field("normal_count", 32'(e.normal_count), 32'(out_data_o.normal_count));
        check_field("warning_count", 32'(e.warning_count), 32'(out_data_o.warning_count));
        check_field("critical_count", 32'(e.critical_count),
                    32'(out_data_o.critical_count));
        check_field("shutdown_count", 32'(e.shutdown_count),
                    32'(out_data_o.shutdown_count));
        check_field("trip_seen", 32'(e.trip_seen), 32'(out_data_o.trip_seen));
        check_field("trip_index", 32'(e.trip_index), 32'(out_data_o.trip_index));
      end
    end
  end

  initial begin
    dir_row_t dir_rows [16];
    cfg_t     next_cfg;
    in_t      b;

    limits = '{NormalLimitReset, WarningLimitReset, CriticalLimitReset, TripLevelReset};
    clear_stats();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      '{ActClear,  16'h0000, 1'b1, StatsReset},
      '{ActSample, 16'h8000, 1'b1,
        stats_of(15'h7FFF, 15'd0, 31'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0)},
      '{ActSample, 16'hFFFF, 1'b1,
        stats_of(15'h7FFF, 15'd0, 31'd0, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0)},
      '{ActSample, 16'h0000, 1'b1,
        stats_of(15'd0, 15'd0, 31'd0, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0)},
      '{ActSample, 16'd464,  1'b0, '0},
      '{ActSample, 16'd465,  1'b0, '0},
      '{ActSample, 16'd704,  1'b0, '0},
      '{ActSample, 16'd719,  1'b0, '0},
      '{ActSample, 16'd720,  1'b0, '0},
      '{ActSample, 16'd944,  1'b0, '0},
      '{ActSample, 16'd945,  1'b0, '0},
      '{ActSample, 16'h7FFF, 1'b0, '0},
      '{ActSample, 16'd100,  1'b0, '0},
      '{ActClear,  16'h7FFF, 1'b1, StatsReset},
      '{ActSample, 16'h7FFF, 1'b1,
        stats_of(15'h7FFF, 15'h7FFF, 31'd32767, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1,
                 16'd0)},
      '{ActSample, 16'h8000, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      b.action = dir_rows[i].act;
      b.sample = dir_rows[i].smp;
      send_beat(b, dir_rows[i].pinned, dir_rows[i].want);
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: next_cfg = '{NormalLimitReset, WarningLimitReset, CriticalLimitReset,
                        TripLevelReset};
        1: next_cfg = '{15'd0, 15'd0, 15'd0, 15'd0};
        2: next_cfg = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
        3: next_cfg = '{15'd20000, 15'd100, 15'd5000, 15'd3000};
        4, 5: begin
          next_cfg.normal_limit = 15'($urandom_range(20000));
          next_cfg.warning_limit = next_cfg.normal_limit + 15'($urandom_range(6000));
          next_cfg.critical_limit = next_cfg.warning_limit + 15'($urandom_range(6000));
          next_cfg.trip_level = 15'($urandom_range(next_cfg.critical_limit,
                                                   next_cfg.normal_limit));
        end
        default: begin
          next_cfg.normal_limit = 15'($urandom);
          next_cfg.warning_limit = 15'($urandom);
          next_cfg.critical_limit = 15'($urandom);
          next_cfg.trip_level = 15'($urandom);
        end
      endcase
      drain();
      set_limits(next_cfg);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int k = 0; k < BeatsPerPhase; k++) begin
        if (ph == 5 && k == BeatsPerPhase / 2) begin
          in_valid_i <= 1'b0;
          while (pending_stats.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        send_beat(rand_item(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Fed %0d sample beats and %0d clears under %0d limit settings;", n_samples,
             n_clears, n_settings);
    $display("%0d result beats compared across band edges, misordered limits and stalls.",
             checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
